// ===== design/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/atft_pkg.sv =====
`timescale 1ns / 1ps

package atft_pkg;

    localparam int TILE_ID_W = 10;
    localparam int REQ_W     = 3;
    localparam int LIMIT_W   = 16;

    localparam logic [REQ_W-1:0] REQ_LOOKUP = 3'd0;
    localparam logic [REQ_W-1:0] REQ_CREATE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_ADD    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_LIMIT  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_TICK   = 3'd4;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd5;

    typedef struct packed {
        logic accept;    // latch the input item, read its table entry
        logic exec;      // apply the request to the entry read
        logic frame;     // take the frame id read from the frame list
        logic sw_rd;     // tick sweep: read created bit, write back pending
        logic sw_clr;    // clear sweep: zero one table entry
        logic load_out;  // move the finished result to the output register
    } t_cmd;

    typedef struct packed {
        logic go_frame;  // lookup of an animated tile needs the frame read
        logic go_tick;
        logic go_clear;
        logic sw_last;   // sweep address is at the last tile
        logic out_free;  // output register can take a result this cycle
    } t_sts;

endpackage

// ===== design/atft_datapath.sv =====
`timescale 1ns / 1ps

module atft_datapath #(
    parameter int TILE_IDS   = 1024,
    parameter int MAX_FRAMES = 8,
    parameter int TIME_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  atft_pkg::t_cmd                      i_cmd,
    output atft_pkg::t_sts                      o_sts,
    input  logic [atft_pkg::REQ_W-1:0]          i_req_type,
    input  logic [atft_pkg::TILE_ID_W-1:0]      i_tile_id,
    input  logic [atft_pkg::TILE_ID_W-1:0]      i_frame_tile,
    input  logic [atft_pkg::LIMIT_W-1:0]        i_time_limit,
    input  logic                                i_out_stall,
    output logic                                o_valid,
    output logic [atft_pkg::TILE_ID_W-1:0]      o_shown_tile,
    output logic                                o_is_animated,
    output logic                                o_error
);

    `include "assert_macros.svh"

    localparam int TW = $clog2(TILE_IDS);
    localparam int XW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW = $clog2(MAX_FRAMES + 1);
    localparam int FD = TILE_IDS * (2 ** XW);
    localparam int IDW = atft_pkg::TILE_ID_W;
    localparam logic [CW-1:0] MAX_CNT   = CW'(MAX_FRAMES);
    localparam logic [TW-1:0] LAST_ADDR = TW'(TILE_IDS - 1);

    // per-tile tables
    logic                 m_created [TILE_IDS];
    logic [CW-1:0]        m_cnt     [TILE_IDS];
    logic [XW-1:0]        m_idx     [TILE_IDS];
    logic [TIME_BITS-1:0] m_tc      [TILE_IDS];
    logic [TIME_BITS-1:0] m_tl      [TILE_IDS];
    logic                 m_lset    [TILE_IDS];
    logic                 m_pend    [TILE_IDS];
    logic [IDW-1:0]       m_frames  [FD];

    // latched request
    logic [atft_pkg::REQ_W-1:0] r_req;
    logic [IDW-1:0]             r_tile;
    logic [IDW-1:0]             r_frame;
    logic [TIME_BITS-1:0]       r_lim;
    logic                       r_ok;
    logic [TW-1:0]              r_addr;

    // registered read data
    logic                 r_rd_created;
    logic [CW-1:0]        r_rd_cnt;
    logic [XW-1:0]        r_rd_idx;
    logic [TIME_BITS-1:0] r_rd_tc;
    logic [TIME_BITS-1:0] r_rd_tl;
    logic                 r_rd_lset;
    logic                 r_rd_pend;
    logic [IDW-1:0]       r_fl_rd;

    logic [TW-1:0] r_sw_addr;
    logic          r_wb_valid;
    logic [TW-1:0] r_wb_addr;

    logic [IDW-1:0] r_res_shown;
    logic           r_res_anim;
    logic           r_res_err;
    logic           r_out_valid;
    logic [IDW-1:0] r_out_shown;
    logic           r_out_anim;
    logic           r_out_err;

    logic [31:0]          tile32;
    logic [31:0]          lim32;
    logic [TW-1:0]        in_addr;
    logic                 in_ok;
    logic [TW-1:0]        rd_addr;
    logic [TW-1:0]        wr_addr;
    logic                 tile_we;
    logic                 pend_we;
    logic [TW-1:0]        pend_addr;
    logic                 pend_data;
    logic                 sw_step;

    logic                 upd_we;
    logic                 upd_created;
    logic [CW-1:0]        upd_cnt;
    logic [XW-1:0]        upd_idx;
    logic [TIME_BITS-1:0] upd_tc;
    logic [TIME_BITS-1:0] upd_tl;
    logic                 upd_lset;
    logic                 upd_pend;
    logic                 fl_we;
    logic [IDW-1:0]       fl_data;
    logic                 ex_err;
    logic                 ex_anim;
    logic                 ex_frame;
    logic                 created;
    logic                 has_room;
    logic [CW-1:0]        idx_p1;
    logic [XW-1:0]        idx_wrap;

    assign tile32  = 32'(i_tile_id);
    assign lim32   = 32'(i_time_limit);
    assign in_addr = tile32[TW-1:0];
    assign in_ok   = tile32 < 32'(TILE_IDS);
    assign sw_step = i_cmd.sw_rd | i_cmd.sw_clr;
    assign rd_addr = i_cmd.sw_rd ? r_sw_addr : in_addr;
    assign wr_addr = i_cmd.sw_clr ? r_sw_addr : r_addr;

    assign created  = r_ok & r_rd_created;
    assign has_room = r_rd_cnt < MAX_CNT;
    assign idx_p1   = CW'(r_rd_idx) + CW'(1);
    assign idx_wrap = (idx_p1 == r_rd_cnt) ? '0 : idx_p1[XW-1:0];

    always_comb begin
        upd_we      = 1'b0;
        upd_created = r_rd_created;
        upd_cnt     = r_rd_cnt;
        upd_idx     = r_rd_idx;
        upd_tc      = r_rd_tc;
        upd_tl      = r_rd_tl;
        upd_lset    = r_rd_lset;
        upd_pend    = r_rd_pend;
        fl_we       = 1'b0;
        fl_data     = r_tile;
        ex_err      = 1'b0;
        ex_anim     = created;
        ex_frame    = 1'b0;
        case (r_req)
            atft_pkg::REQ_LOOKUP: begin
                if (created && r_rd_cnt != '0) begin
                    ex_frame = 1'b1;
                    if (!r_rd_lset) begin
                        ex_err = 1'b1;
                    end else begin
                        upd_we = 1'b1;
                        if (r_rd_tc == r_rd_tl) begin
                            upd_idx = idx_wrap;
                            upd_tc  = '0;
                        end
                        if (r_rd_pend) begin
                            upd_tc   = upd_tc + TIME_BITS'(1);
                            upd_pend = 1'b0;
                        end
                    end
                end
            end
            atft_pkg::REQ_CREATE: begin
                if (!r_ok) begin
                    ex_err = 1'b1;
                end else begin
                    upd_we      = 1'b1;
                    upd_created = 1'b1;
                    upd_idx     = '0;
                    upd_pend    = 1'b0;
                    ex_anim     = 1'b1;
                    if (has_room) begin
                        fl_we   = 1'b1;
                        upd_cnt = r_rd_cnt + CW'(1);
                    end else begin
                        ex_err = 1'b1;
                    end
                end
            end
            atft_pkg::REQ_ADD: begin
                if (created && has_room) begin
                    upd_we  = 1'b1;
                    fl_we   = 1'b1;
                    fl_data = r_frame;
                    upd_cnt = r_rd_cnt + CW'(1);
                end else begin
                    ex_err = 1'b1;
                end
            end
            atft_pkg::REQ_LIMIT: begin
                if (!created) begin
                    ex_err = 1'b1;
                end else begin
                    upd_we   = 1'b1;
                    upd_tc   = '0;
                    upd_tl   = r_lim;
                    upd_lset = 1'b1;
                end
            end
            atft_pkg::REQ_CLEAR: begin
                ex_anim = 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign tile_we   = i_cmd.sw_clr | (i_cmd.exec & upd_we);
    assign pend_we   = tile_we | r_wb_valid;
    assign pend_addr = r_wb_valid ? r_wb_addr : wr_addr;
    assign pend_data = r_wb_valid ? r_rd_created : (!i_cmd.sw_clr & upd_pend);

    // tile tables: one read and one write port each
    always_ff @(posedge i_clk) begin
        if (tile_we) begin
            m_created[wr_addr] <= i_cmd.sw_clr ? 1'b0 : upd_created;
            m_cnt[wr_addr]     <= i_cmd.sw_clr ? '0 : upd_cnt;
            m_idx[wr_addr]     <= i_cmd.sw_clr ? '0 : upd_idx;
            m_tc[wr_addr]      <= i_cmd.sw_clr ? '0 : upd_tc;
            m_tl[wr_addr]      <= i_cmd.sw_clr ? '0 : upd_tl;
            m_lset[wr_addr]    <= i_cmd.sw_clr ? 1'b0 : upd_lset;
        end
        if (pend_we) begin
            m_pend[pend_addr] <= pend_data;
        end
        r_rd_created <= m_created[rd_addr];
        r_rd_cnt     <= m_cnt[rd_addr];
        r_rd_idx     <= m_idx[rd_addr];
        r_rd_tc      <= m_tc[rd_addr];
        r_rd_tl      <= m_tl[rd_addr];
        r_rd_lset    <= m_lset[rd_addr];
        r_rd_pend    <= m_pend[rd_addr];
    end

    // frame list: append at the fill count, read at the frame index
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && fl_we) begin
            m_frames[{r_addr, r_rd_cnt[XW-1:0]}] <= fl_data;
        end
        r_fl_rd <= m_frames[{r_addr, r_rd_idx}];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req   <= i_req_type;
            r_tile  <= i_tile_id;
            r_frame <= i_frame_tile;
            r_lim   <= lim32[TIME_BITS-1:0];
            r_ok    <= in_ok;
            r_addr  <= in_addr;
        end
        if (i_cmd.exec) begin
            r_res_shown <= r_tile;
            r_res_anim  <= ex_anim;
            r_res_err   <= ex_err;
        end else if (i_cmd.frame) begin
            r_res_shown <= r_fl_rd;
        end
        if (i_cmd.load_out) begin
            r_out_shown <= r_res_shown;
            r_out_anim  <= r_res_anim;
            r_out_err   <= r_res_err;
        end
        r_wb_addr <= r_sw_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw_addr   <= '0;
            r_wb_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (sw_step) begin
                r_sw_addr <= (r_sw_addr == LAST_ADDR) ? '0 : r_sw_addr + TW'(1);
            end
            r_wb_valid <= i_cmd.sw_rd;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.go_frame = ex_frame;
    assign o_sts.go_tick  = r_req == atft_pkg::REQ_TICK;
    assign o_sts.go_clear = r_req == atft_pkg::REQ_CLEAR;
    assign o_sts.sw_last  = r_sw_addr == LAST_ADDR;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_valid       = r_out_valid;
    assign o_shown_tile  = r_out_shown;
    assign o_is_animated = r_out_anim;
    assign o_error       = r_out_err;

    `ASSERT_NEXT(a_sw_addr_hold, i_clk, i_rst_n, !sw_step, $stable(r_sw_addr))
    `ASSERT_IMPLIES(a_wb_no_clash, i_clk, i_rst_n, r_wb_valid, !i_cmd.exec && !i_cmd.sw_clr)

endmodule

// ===== design/atft_ctrl.sv =====
`timescale 1ns / 1ps

module atft_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  atft_pkg::t_sts i_sts,
    output atft_pkg::t_cmd o_cmd
);

    `include "assert_macros.svh"

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_EXEC,
        S_FRAME,
        S_TICK,
        S_DRAIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_res_pend;
    logic   n_res_pend;
    logic   res_room;
    logic   set_res;

    always_comb begin
        o_cmd          = '0;
        n_state        = r_state;
        res_room       = !r_res_pend || i_sts.out_free;
        o_cmd.load_out = r_res_pend && i_sts.out_free;
        o_stall        = !(r_state == S_IDLE && res_room);
        case (r_state)
            S_CLR: begin
                o_cmd.sw_clr = 1'b1;
                if (i_sts.sw_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid && res_room) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.go_frame) begin
                    n_state = S_FRAME;
                end else if (i_sts.go_tick) begin
                    n_state = S_TICK;
                end else if (i_sts.go_clear) begin
                    n_state = S_CLR;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FRAME: begin
                o_cmd.frame = 1'b1;
                n_state     = S_IDLE;
            end
            S_TICK: begin
                o_cmd.sw_rd = 1'b1;
                if (i_sts.sw_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        set_res    = (o_cmd.exec && !i_sts.go_frame) || o_cmd.frame;
        n_res_pend = set_res ? 1'b1 : (o_cmd.load_out ? 1'b0 : r_res_pend);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_res_pend <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_res_pend <= n_res_pend;
        end
    end

    `ASSERT_NEXT(a_res_kept, i_clk, i_rst_n, r_res_pend && !i_sts.out_free, r_res_pend)
    `ASSERT_IMPLIES(a_sweep_stall, i_clk, i_rst_n, r_state == S_TICK || r_state == S_CLR, o_stall)
    `ASSERT_NEXT(a_frame_follows, i_clk, i_rst_n, r_state == S_EXEC && i_sts.go_frame,
                 r_state == S_FRAME)

endmodule

// ===== design/animated_tile_frame_table_top.sv =====
`timescale 1ns / 1ps

// Animated tile frame table: every base tile id may be created as animated and
// then owns a list of up to MAX_FRAMES frame ids, a frame index and a tick
// counter with a limit. Each request item yields exactly one result item.
// A create, add frame, set limit or unknown request reads the tile's table
// entry when it is accepted and updates it in the execute step; a lookup of an
// animated tile adds a frame step, since the frame list is read at the frame
// index that the first read returns. A frame tick then sweeps every table
// entry once to set its pending mark and ends with a drain step; clear all runs
// a zeroing sweep. After reset a clearing pass over every entry runs before the
// first item is taken. The result goes into an output register, so the next
// item is taken while a result waits there.
module animated_tile_frame_table_top #(
    parameter int TILE_IDS   = 1024,
    parameter int MAX_FRAMES = 8,
    parameter int TIME_BITS  = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [atft_pkg::REQ_W-1:0]     i_req_type,
    input  logic [atft_pkg::TILE_ID_W-1:0] i_tile_id,
    input  logic [atft_pkg::TILE_ID_W-1:0] i_frame_tile,
    input  logic [atft_pkg::LIMIT_W-1:0]   i_time_limit,
    // result channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [atft_pkg::TILE_ID_W-1:0] o_shown_tile,
    output logic                           o_is_animated,
    output logic                           o_error
);

    atft_pkg::t_cmd cmd;
    atft_pkg::t_sts sts;

    // Sequencing: accept, execute, optional frame read, sweeps.
    atft_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Tables, frame list, update logic and the output register.
    atft_datapath #(
        .TILE_IDS   (TILE_IDS),
        .MAX_FRAMES (MAX_FRAMES),
        .TIME_BITS  (TIME_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_req_type    (i_req_type),
        .i_tile_id     (i_tile_id),
        .i_frame_tile  (i_frame_tile),
        .i_time_limit  (i_time_limit),
        .i_out_stall   (i_stall),
        .o_valid       (o_valid),
        .o_shown_tile  (o_shown_tile),
        .o_is_animated (o_is_animated),
        .o_error       (o_error)
    );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int TILE_N          = 1024;
    localparam int FRAMES_MAX      = 8;
    localparam int ITEMS_PER_PHASE = 270;
    localparam int HOT_TILES       = 8;
    localparam int LONG_HOLD       = 200;   // receiver hold-off that backs up the table
    localparam int QUIET_LIMIT     = 10000; // several full sweeps plus the longest hold
    localparam int TAIL_CYCLES     = 50;
    localparam int SCRIPT_LEN      = 26;
    localparam int TID_W           = atft_pkg::TILE_ID_W;

    // request kinds that the table must treat as no-ops
    localparam logic [atft_pkg::REQ_W-1:0] REQ_RSVD6 = 3'd6;
    localparam logic [atft_pkg::REQ_W-1:0] REQ_RSVD7 = 3'd7;
    localparam logic [atft_pkg::TILE_ID_W-1:0] TOP_TILE = 10'h3FF;

    typedef struct packed {
        logic [atft_pkg::TILE_ID_W-1:0] shown;
        logic                           anim;
        logic                           err;
    } t_tile_view;

    // one directed request; typed rows carry their own expected view
    typedef struct packed {
        logic [atft_pkg::REQ_W-1:0]     kind;
        logic [atft_pkg::TILE_ID_W-1:0] tile;
        logic [atft_pkg::TILE_ID_W-1:0] frame;
        logic [atft_pkg::LIMIT_W-1:0]   lim;
        logic                           typed;
        t_tile_view                     view;
    } t_script_row;

    localparam t_tile_view NO_VIEW = '0;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_stall;
    logic [atft_pkg::REQ_W-1:0]     i_req_type;
    logic [atft_pkg::TILE_ID_W-1:0] i_tile_id;
    logic [atft_pkg::TILE_ID_W-1:0] i_frame_tile;
    logic [atft_pkg::LIMIT_W-1:0]   i_time_limit;
    logic                           o_valid;
    logic                           i_stall;
    logic [atft_pkg::TILE_ID_W-1:0] o_shown_tile;
    logic                           o_is_animated;
    logic                           o_error;

    animated_tile_frame_table_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_req_type    (i_req_type),
        .i_tile_id     (i_tile_id),
        .i_frame_tile  (i_frame_tile),
        .i_time_limit  (i_time_limit),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_shown_tile  (o_shown_tile),
        .o_is_animated (o_is_animated),
        .o_error       (o_error)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the animation table
    // ------------------------------------------------------------------
    bit                             created      [TILE_N];
    logic [3:0]                     nframes      [TILE_N];
    logic [atft_pkg::TILE_ID_W-1:0] frames       [TILE_N][FRAMES_MAX];
    logic [2:0]                     cur_frame    [TILE_N];
    logic [15:0]                    ticks        [TILE_N];
    logic [15:0]                    limits       [TILE_N];
    bit                             has_limit    [TILE_N];
    bit                             tick_pending [TILE_N];

    t_tile_view expected_views[$];

    int phase_idx;
    int send_idle_pct  [4] = '{0, 51, 0, 30};
    int recv_stall_pct [4] = '{0, 0, 51, 30};
    int items_taken;
    int results_checked;
    int fail_count;
    int frame_advances;
    int full_rejects;
    int kind_seen [8];
    int quiet_cycles;
    bit long_hold_done;

    // Zero every per-tile field; the frame lists keep their contents since
    // only entries below the frame count are ever read.
    function automatic void wipe_tables();
        for (int t = 0; t < TILE_N; t++) begin
            created[t]      = 1'b0;
            nframes[t]      = '0;
            cur_frame[t]    = '0;
            ticks[t]        = '0;
            limits[t]       = '0;
            has_limit[t]    = 1'b0;
            tick_pending[t] = 1'b0;
        end
    endfunction

    function automatic bit push_frame(int t, logic [atft_pkg::TILE_ID_W-1:0] f);
        if (nframes[t] >= FRAMES_MAX) begin
            full_rejects++;
            return 1'b0;
        end
        frames[t][nframes[t]] = f;
        nframes[t] = nframes[t] + 4'd1;
        return 1'b1;
    endfunction

    // Apply one request to the shadow table and return the view it yields.
    function automatic t_tile_view animate_step(logic [atft_pkg::REQ_W-1:0] kind,
                                                logic [atft_pkg::TILE_ID_W-1:0] tile,
                                                logic [atft_pkg::TILE_ID_W-1:0] frame,
                                                logic [atft_pkg::LIMIT_W-1:0] lim);
        t_tile_view v;
        int t;
        int n;
        int idx;
        t = int'(tile);
        v.shown = tile;
        v.err   = 1'b0;
        case (kind)
            atft_pkg::REQ_LOOKUP: begin
                if (created[t] && nframes[t] != 0) begin
                    n = int'(nframes[t]);
                    idx = int'(cur_frame[t]) % n;
                    v.shown = frames[t][idx];
                    if (!has_limit[t]) begin
                        v.err = 1'b1;
                    end else begin
                        if (ticks[t] == limits[t]) begin
                            cur_frame[t] = 3'((idx + 1) % n);
                            ticks[t] = '0;
                            frame_advances++;
                        end
                        if (tick_pending[t]) begin
                            ticks[t] = ticks[t] + 16'd1;
                            tick_pending[t] = 1'b0;
                        end
                    end
                end
            end
            atft_pkg::REQ_CREATE: begin
                if (!push_frame(t, tile)) v.err = 1'b1;
                created[t]      = 1'b1;
                cur_frame[t]    = '0;
                tick_pending[t] = 1'b0;
            end
            atft_pkg::REQ_ADD: begin
                if (!created[t]) v.err = 1'b1;
                else if (!push_frame(t, frame)) v.err = 1'b1;
            end
            atft_pkg::REQ_LIMIT: begin
                if (!created[t]) begin
                    v.err = 1'b1;
                end else begin
                    ticks[t]     = '0;
                    limits[t]    = lim;
                    has_limit[t] = 1'b1;
                end
            end
            atft_pkg::REQ_TICK: begin
                for (int i = 0; i < TILE_N; i++)
                    if (created[i]) tick_pending[i] = 1'b1;
            end
            atft_pkg::REQ_CLEAR: wipe_tables();
            default: ;
        endcase
        v.anim = created[t];
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Request side: idle at random, then hold the item until it is taken
    // ------------------------------------------------------------------
    task automatic offer(input logic [atft_pkg::REQ_W-1:0] kind,
                         input logic [atft_pkg::TILE_ID_W-1:0] tile,
                         input logic [atft_pkg::TILE_ID_W-1:0] frame,
                         input logic [atft_pkg::LIMIT_W-1:0] lim,
                         input logic typed, input t_tile_view typed_view);
        t_tile_view v;
        bit taken;
        while ($urandom_range(0, 99) < send_idle_pct[phase_idx]) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_req_type   <= kind;
        i_tile_id    <= tile;
        i_frame_tile <= frame;
        i_time_limit <= lim;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !o_stall;
            if (taken) begin
                // predict on every item so the shadow table stays in step
                v = animate_step(kind, tile, frame, lim);
                expected_views = {expected_views, (typed ? typed_view : v)};
                kind_seen[kind]++;
                items_taken++;
            end
            @(negedge i_clk);
        end
    endtask

    function automatic logic [atft_pkg::TILE_ID_W-1:0] pick_tile(int hot []);
        int pick;
        if ($urandom_range(0, 99) < 85) pick = hot[$urandom_range(0, HOT_TILES - 1)];
        else pick = int'($urandom_range(0, TILE_N - 1));
        return pick[atft_pkg::TILE_ID_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Result side: stall at random; once in the first phase, hold off long
    // enough that the table backs up and stalls its request side.
    // ------------------------------------------------------------------
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (phase_idx == 0 && !long_hold_done && items_taken >= 40) begin
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                long_hold_done = 1'b1;
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(0, 99) < recv_stall_pct[phase_idx]);
            end
        end
    end

    task automatic compare_field(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            fail_count++;
        end
    endtask

    // Check each result item against the oldest outstanding expectation.
    always @(posedge i_clk) begin
        t_tile_view want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_views.size() == 0) begin
                $display("%0t: unexpected result, shown %0d animated %0b error %0b",
                         $time, o_shown_tile, o_is_animated, o_error);
                fail_count++;
            end else begin
                want = expected_views.pop_front();
                compare_field("shown_tile", 32'(want.shown), 32'(o_shown_tile));
                compare_field("is_animated", 32'(want.anim), 32'(o_is_animated));
                compare_field("error", 32'(want.err), 32'(o_error));
            end
            results_checked++;
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: watchdog, no handshake for %0d cycles", $time, quiet_cycles);
                $display("CHECKS FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        t_script_row                    script [SCRIPT_LEN];
        int                             hot [];
        int                             roll;
        logic [atft_pkg::REQ_W-1:0]     kind;
        logic [atft_pkg::TILE_ID_W-1:0] tile;
        logic [atft_pkg::TILE_ID_W-1:0] frame;
        logic [atft_pkg::LIMIT_W-1:0]   lim;

        phase_idx    = 0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_req_type   = atft_pkg::REQ_LOOKUP;
        i_tile_id    = '0;
        i_frame_tile = '0;
        i_time_limit = '0;
        quiet_cycles = 0;
        wipe_tables();

        // Directed sweep: untouched tiles, reserved kinds, filling one list
        // to the top, no-limit lookups, limit extremes, tick and clear.
        script = '{
            '{atft_pkg::REQ_LOOKUP, 10'd0, 10'd0, 16'd0, 1'b1, '{10'd0, 1'b0, 1'b0}},
            '{atft_pkg::REQ_ADD, 10'd5, 10'h2AA, 16'd0, 1'b1, '{10'd5, 1'b0, 1'b1}},
            '{atft_pkg::REQ_LIMIT, 10'd5, 10'd0, 16'hFFFF, 1'b1, '{10'd5, 1'b0, 1'b1}},
            '{REQ_RSVD6, 10'd7, 10'h3FF, 16'hFFFF, 1'b1, '{10'd7, 1'b0, 1'b0}},
            '{REQ_RSVD7, TOP_TILE, 10'h155, 16'h5555, 1'b1, '{TOP_TILE, 1'b0, 1'b0}},
            '{atft_pkg::REQ_CREATE, TOP_TILE, 10'd0, 16'd0, 1'b1, '{TOP_TILE, 1'b1, 1'b0}},
            // animated but no limit yet: frame shown, error raised
            '{atft_pkg::REQ_LOOKUP, TOP_TILE, 10'd0, 16'd0, 1'b1, '{TOP_TILE, 1'b1, 1'b1}},
            '{atft_pkg::REQ_ADD, TOP_TILE, 10'h000, 16'd0, 1'b1, '{TOP_TILE, 1'b1, 1'b0}},
            '{atft_pkg::REQ_ADD, TOP_TILE, 10'h3FF, 16'd0, 1'b1, '{TOP_TILE, 1'b1, 1'b0}},
            '{atft_pkg::REQ_ADD, TOP_TILE, 10'h155, 16'd0, 1'b1, '{TOP_TILE, 1'b1, 1'b0}},
            '{atft_pkg::REQ_ADD, TOP_TILE, 10'h2AA, 16'd0, 1'b1, '{TOP_TILE, 1'b1, 1'b0}},
            '{atft_pkg::REQ_ADD, TOP_TILE, 10'h001, 16'd0, 1'b1, '{TOP_TILE, 1'b1, 1'b0}},
            '{atft_pkg::REQ_ADD, TOP_TILE, 10'h200, 16'd0, 1'b1, '{TOP_TILE, 1'b1, 1'b0}},
            '{atft_pkg::REQ_ADD, TOP_TILE, 10'h0F0, 16'd0, 1'b1, '{TOP_TILE, 1'b1, 1'b0}},
            // list is full now: both add and re-create are refused
            '{atft_pkg::REQ_ADD, TOP_TILE, 10'h123, 16'd0, 1'b1, '{TOP_TILE, 1'b1, 1'b1}},
            '{atft_pkg::REQ_CREATE, TOP_TILE, 10'd0, 16'd0, 1'b1, '{TOP_TILE, 1'b1, 1'b1}},
            '{atft_pkg::REQ_LIMIT, TOP_TILE, 10'd0, 16'd0, 1'b1, '{TOP_TILE, 1'b1, 1'b0}},
            '{atft_pkg::REQ_LOOKUP, TOP_TILE, 10'd0, 16'd0, 1'b0, NO_VIEW},
            '{atft_pkg::REQ_LOOKUP, TOP_TILE, 10'd0, 16'd0, 1'b0, NO_VIEW},
            '{atft_pkg::REQ_TICK, 10'd0, 10'd0, 16'd0, 1'b1, '{10'd0, 1'b0, 1'b0}},
            '{atft_pkg::REQ_LOOKUP, TOP_TILE, 10'd0, 16'd0, 1'b0, NO_VIEW},
            '{atft_pkg::REQ_LIMIT, TOP_TILE, 10'd0, 16'hFFFF, 1'b1, '{TOP_TILE, 1'b1, 1'b0}},
            // re-create of a tile whose list still has room
            '{atft_pkg::REQ_CREATE, 10'd0, 10'd0, 16'd0, 1'b1, '{10'd0, 1'b1, 1'b0}},
            '{atft_pkg::REQ_CREATE, 10'd0, 10'd0, 16'd0, 1'b1, '{10'd0, 1'b1, 1'b0}},
            '{atft_pkg::REQ_CLEAR, TOP_TILE, 10'd0, 16'd0, 1'b1, '{TOP_TILE, 1'b0, 1'b0}},
            '{atft_pkg::REQ_LOOKUP, 10'd0, 10'd0, 16'd0, 1'b1, '{10'd0, 1'b0, 1'b0}}
        };

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[r])
            offer(script[r].kind, script[r].tile, script[r].frame, script[r].lim,
                  script[r].typed, script[r].view);

        // Random part: mostly traffic on a few hot tiles so their lists fill
        // and their counters reach small limits; the rest lands anywhere.
        hot = new[HOT_TILES];
        hot[0] = 0;
        hot[1] = TILE_N - 1;
        for (int h = 2; h < HOT_TILES; h++) hot[h] = int'($urandom_range(0, TILE_N - 1));

        for (int p = 0; p < 4; p++) begin
            phase_idx = p;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                roll  = $urandom_range(0, 999);
                tile  = pick_tile(hot);
                frame = TID_W'($urandom);
                lim   = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 3)) : 16'($urandom);
                if (roll < 120)      kind = atft_pkg::REQ_CREATE;
                else if (roll < 250) kind = atft_pkg::REQ_ADD;
                else if (roll < 360) kind = atft_pkg::REQ_LIMIT;
                else if (roll < 430) kind = atft_pkg::REQ_TICK;
                else if (roll < 438) kind = atft_pkg::REQ_CLEAR;
                else if (roll < 453) kind = $urandom_range(0, 1) ? REQ_RSVD6 : REQ_RSVD7;
                else                 kind = atft_pkg::REQ_LOOKUP;
                offer(kind, tile, frame, lim, 1'b0, NO_VIEW);
            end
        end
        i_valid <= 1'b0;

        // Drain, then give stray results a chance to show up.
        while (expected_views.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d requests: %0d lookups, %0d creates, %0d adds, %0d limits,",
                 items_taken, kind_seen[atft_pkg::REQ_LOOKUP], kind_seen[atft_pkg::REQ_CREATE],
                 kind_seen[atft_pkg::REQ_ADD], kind_seen[atft_pkg::REQ_LIMIT]);
        $display("  %0d ticks, %0d clears; %0d results, %0d frame steps, %0d full-list refusals",
                 kind_seen[atft_pkg::REQ_TICK], kind_seen[atft_pkg::REQ_CLEAR],
                 results_checked, frame_advances, full_rejects);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
